// File: rtl/tpq_pkg.sv
// Shared types and codes for the time-ordered priority queue.
`default_nettype none

package tpq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int TIME_WIDTH_DEFAULT = 32;
  localparam int TAG_W = 16;
  localparam int FIELD_TIME_W = 32;
  localparam int OCC_W = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    action;
    logic [FIELD_TIME_W-1:0] item_time;
    logic [TAG_W-1:0]        item_tag;
  } req_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [FIELD_TIME_W-1:0] out_time;
    logic [TAG_W-1:0]        out_tag;
    logic [FIELD_TIME_W-1:0] head_time;
    logic                    is_empty;
    logic [OCC_W-1:0]        occupancy;
  } rsp_word_t;

  // per-cycle command broadcast along the row of cells
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/tpq_cell.sv
// One slot of the sorted row: holds a time and tag, shifts towards either neighbour.
`default_nettype none

module tpq_cell #(
  parameter int TIME_WIDTH = tpq_pkg::TIME_WIDTH_DEFAULT
) (
  input  wire                        clk,
  input  wire tpq_pkg::cell_ctrl_t   ctrl,
  input  wire                        occupied,
  input  wire [TIME_WIDTH-1:0]       new_time,
  input  wire [tpq_pkg::TAG_W-1:0]   new_tag,
  input  wire                        left_beyond,
  input  wire [TIME_WIDTH-1:0]       left_time,
  input  wire [tpq_pkg::TAG_W-1:0]   left_tag,
  input  wire [TIME_WIDTH-1:0]       right_time,
  input  wire [tpq_pkg::TAG_W-1:0]   right_tag,
  output logic                       beyond,
  output logic [TIME_WIDTH-1:0]      slot_time,
  output logic [tpq_pkg::TAG_W-1:0]  slot_tag,
  output logic [TIME_WIDTH-1:0]      slot_time_next
);

  logic [tpq_pkg::TAG_W-1:0] slot_tag_next;

  // new word goes after every entry with time <= its own
  assign beyond = !occupied || (slot_time > new_time);

  always_comb begin
    slot_time_next = slot_time;
    slot_tag_next  = slot_tag;
    priority if (ctrl.ins) begin
      if (beyond) begin
        if (left_beyond) begin
          slot_time_next = left_time;
          slot_tag_next  = left_tag;
        end else begin
          slot_time_next = new_time;
          slot_tag_next  = new_tag;
        end
      end
    end else if (ctrl.rem) begin
      slot_time_next = right_time;
      slot_tag_next  = right_tag;
    end else begin
      slot_time_next = slot_time;
      slot_tag_next  = slot_tag;
    end
  end

  always_ff @(posedge clk) begin
    slot_time <= slot_time_next;
    slot_tag  <= slot_tag_next;
  end

endmodule

`default_nettype wire

// File: rtl/time_ordered_priority_queue.sv
// Top level of the time-ordered priority queue: row of slot cells and result register.
// A result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one request per cycle; all slots compare against the new time at once
// and shift in the same cycle, so only a stalled result register holds back requests.
// Reset (rst, synchronous, active high) empties the queue and clears the result valid;
// slot contents are not cleared and are never read until written.
`default_nettype none

module time_ordered_priority_queue #(
  parameter int DEPTH = tpq_pkg::DEPTH_DEFAULT,
  parameter int TIME_WIDTH = tpq_pkg::TIME_WIDTH_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  wire tpq_pkg::req_word_t req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output tpq_pkg::rsp_word_t  rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic                       accept;
  logic                       full;
  logic                       empty;
  logic [TIME_WIDTH-1:0]      new_time;
  tpq_pkg::cell_ctrl_t        ctrl;
  tpq_pkg::rsp_word_t         rsp_next;

  logic                       beyond [DEPTH];
  logic [TIME_WIDTH-1:0]      times [DEPTH];
  logic [tpq_pkg::TAG_W-1:0]  tags [DEPTH];
  logic [TIME_WIDTH-1:0]      times_next [DEPTH];

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign new_time  = TIME_WIDTH'(req.item_time);

  assign ctrl.ins = accept && (req.action == tpq_pkg::ACT_INSERT) && !full;
  assign ctrl.rem = accept && (req.action == tpq_pkg::ACT_REMOVE) && !empty;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                      l_beyond;
      logic [TIME_WIDTH-1:0]     l_time;
      logic [tpq_pkg::TAG_W-1:0] l_tag;
      logic [TIME_WIDTH-1:0]     r_time;
      logic [tpq_pkg::TAG_W-1:0] r_tag;

      if (i == 0) begin : g_first
        assign l_beyond = 1'b0;
        assign l_time   = new_time;
        assign l_tag    = req.item_tag;
      end else begin : g_mid
        assign l_beyond = beyond[i-1];
        assign l_time   = times[i-1];
        assign l_tag    = tags[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign r_time = times[i];
        assign r_tag  = tags[i];
      end else begin : g_inner
        assign r_time = times[i+1];
        assign r_tag  = tags[i+1];
      end

      tpq_cell #(
        .TIME_WIDTH(TIME_WIDTH)
      ) u_cell (
        .clk            (clk),
        .ctrl           (ctrl),
        .occupied       (CW'(i) < count),
        .new_time       (new_time),
        .new_tag        (req.item_tag),
        .left_beyond    (l_beyond),
        .left_time      (l_time),
        .left_tag       (l_tag),
        .right_time     (r_time),
        .right_tag      (r_tag),
        .beyond         (beyond[i]),
        .slot_time      (times[i]),
        .slot_tag       (tags[i]),
        .slot_time_next (times_next[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    rsp_next.status    = tpq_pkg::ST_DONE;
    rsp_next.out_time  = '0;
    rsp_next.out_tag   = '0;
    if (req.action == tpq_pkg::ACT_INSERT) begin
      if (full) begin
        rsp_next.status = tpq_pkg::ST_FULL;
      end
    end else if (empty) begin
      rsp_next.status = tpq_pkg::ST_EMPTY;
    end else begin
      rsp_next.out_time = tpq_pkg::FIELD_TIME_W'(times[0]);
      rsp_next.out_tag  = tags[0];
    end
    rsp_next.head_time = (count_next != '0) ? tpq_pkg::FIELD_TIME_W'(times_next[0]) : '0;
    rsp_next.is_empty  = (count_next == '0);
    rsp_next.occupancy = tpq_pkg::OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (times[0] <= times[1]))
    else $error("front slots out of order");

  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.action == tpq_pkg::ACT_INSERT) && full) |=> $stable(count))
    else $error("refused insert changed occupancy");

  a_word_issued: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp_valid && (rsp.occupancy == tpq_pkg::OCC_W'(count))))
    else $error("result word missing or stale");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the time-ordered priority queue: directed and random traffic against a predictor.
`default_nettype none

module tb_top;

  localparam int SLOTS = tpq_pkg::DEPTH_DEFAULT;

  typedef struct packed {
    tpq_pkg::req_word_t word;
    logic [7:0]         gap;
    logic               drain;
  } backlog_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  tpq_pkg::req_word_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  tpq_pkg::rsp_word_t rsp;

  time_ordered_priority_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // shadow copy of the slot row, slot 0 at the front
  logic [tpq_pkg::FIELD_TIME_W-1:0] slot_time [SLOTS];
  logic [tpq_pkg::TAG_W-1:0]        slot_tag [SLOTS];
  int                               slot_count = 0;

  backlog_item_t      req_backlog[$];
  tpq_pkg::rsp_word_t rsp_due[$];
  int                 in_flight = 0;
  bit                 stim_done = 1'b0;
  int                 fail_cnt = 0;

  function automatic tpq_pkg::rsp_word_t queue_step(tpq_pkg::req_word_t w);
    tpq_pkg::rsp_word_t r;
    int pos;
    int i;
    r = '0;
    r.status = tpq_pkg::ST_DONE;
    if (w.action == tpq_pkg::ACT_INSERT) begin
      if (slot_count >= SLOTS) begin
        r.status = tpq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < slot_count && slot_time[pos] <= w.item_time) pos++;
        for (i = slot_count; i > pos; i--) begin
          slot_time[i] = slot_time[i-1];
          slot_tag[i] = slot_tag[i-1];
        end
        slot_time[pos] = w.item_time;
        slot_tag[pos] = w.item_tag;
        slot_count++;
      end
    end else begin
      if (slot_count == 0) begin
        r.status = tpq_pkg::ST_EMPTY;
      end else begin
        r.out_time = slot_time[0];
        r.out_tag = slot_tag[0];
        for (i = 1; i < slot_count; i++) begin
          slot_time[i-1] = slot_time[i];
          slot_tag[i-1] = slot_tag[i];
        end
        slot_count--;
      end
    end
    r.head_time = (slot_count > 0) ? slot_time[0] : '0;
    r.is_empty = (slot_count == 0);
    r.occupancy = tpq_pkg::OCC_W'(slot_count);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // clustered times give plenty of ties
  function automatic logic [tpq_pkg::FIELD_TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return $urandom_range(0, 7);
      5: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(logic act, logic [tpq_pkg::FIELD_TIME_W-1:0] t,
                           logic [tpq_pkg::TAG_W-1:0] tag, int unsigned gap, bit drain);
    backlog_item_t b;
    b.word.action = act;
    b.word.item_time = t;
    b.word.item_tag = tag;
    b.gap = 8'(gap);
    b.drain = drain;
    req_backlog.push_back(b);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    int n;
    int ins_pct;
    bit calm_run;
    tpq_pkg::req_word_t w;
    ins_pct = 50;
    calm_run = 1'b0;
    // directed: empty remove, ties, extremes, fill up, refused insert, partial drain
    push_word(tpq_pkg::ACT_REMOVE, '1, '1, 0, 1'b0);
    push_word(tpq_pkg::ACT_INSERT, 32'd5, 16'd1, 0, 1'b0);
    push_word(tpq_pkg::ACT_INSERT, 32'd0, 16'd2, 0, 1'b0);
    push_word(tpq_pkg::ACT_INSERT, '1, '1, 0, 1'b0);
    push_word(tpq_pkg::ACT_INSERT, 32'd5, 16'd4, 0, 1'b0);
    push_word(tpq_pkg::ACT_INSERT, 32'd5, 16'd5, 0, 1'b0);
    push_word(tpq_pkg::ACT_INSERT, 32'd0, 16'd6, 0, 1'b0);
    for (n = 0; n < 10; n++) begin
      push_word(tpq_pkg::ACT_INSERT, 32'(n * 3), 16'(100 + n), 0, 1'b0);
    end
    push_word(tpq_pkg::ACT_INSERT, 32'd1, 16'hBEEF, 0, 1'b0);
    for (n = 0; n < 4; n++) push_word(tpq_pkg::ACT_REMOVE, '0, '0, 0, 1'b0);
    for (n = 0; n < 1500; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 4))
          0: ins_pct = 90;
          1: ins_pct = 70;
          2: ins_pct = 50;
          3: ins_pct = 30;
          default: ins_pct = 10;
        endcase
        calm_run = ($urandom_range(0, 3) == 0);
      end
      w.action = ($urandom_range(0, 99) < ins_pct) ? tpq_pkg::ACT_INSERT : tpq_pkg::ACT_REMOVE;
      w.item_time = pick_time();
      w.item_tag = 16'($urandom_range(0, 65535));
      push_word(w.action, w.item_time, w.item_tag, calm_run ? 0 : pick_gap(),
                (n == 0) || (n % 500 == 250));
    end
  end

  // request driver
  backlog_item_t cur;
  bit            staged = 1'b0;
  int unsigned   gap_left = 0;

  always @(posedge clk) begin
    logic nv;
    tpq_pkg::req_word_t nw;
    nv = 1'b0;
    nw = req;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        rsp_due.push_back(queue_step(req));
        in_flight++;
      end
      if (rsp_valid && !rsp_stall) in_flight--;
      if (req_valid && req_stall) begin
        nv = 1'b1;
      end else begin
        if (!staged && req_backlog.size() > 0) begin
          cur = req_backlog.pop_front();
          staged = 1'b1;
          gap_left = 32'(cur.gap);
        end
        if (staged) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!(cur.drain && in_flight != 0)) begin
            nv = 1'b1;
            nw = cur.word;
            staged = 1'b0;
          end
        end else begin
          stim_done = 1'b1;
        end
      end
      req_valid <= nv;
      req <= nw;
    end
  end

  // result receiver: random stalls plus two long hold-offs
  int unsigned stall_left = 0;
  int unsigned taken_cnt = 0;
  int unsigned next_hold_at = 500;
  int unsigned rcv_cyc = 0;
  bit          calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rcv_cyc++;
      if (rcv_cyc % 200 == 0) calm = ($urandom_range(0, 3) == 0);
      if (rsp_valid && !rsp_stall) taken_cnt++;
      if (taken_cnt == next_hold_at) begin
        stall_left = 80;
        next_hold_at += 600;
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    tpq_pkg::rsp_word_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        $error("result word with no request outstanding");
        fail_cnt++;
      end else begin
        e = rsp_due.pop_front();
        if (rsp.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, rsp.status);
          fail_cnt++;
        end
        if (rsp.out_time !== e.out_time) begin
          $error("out_time expected %0h got %0h", e.out_time, rsp.out_time);
          fail_cnt++;
        end
        if (rsp.out_tag !== e.out_tag) begin
          $error("out_tag expected %0h got %0h", e.out_tag, rsp.out_tag);
          fail_cnt++;
        end
        if (rsp.head_time !== e.head_time) begin
          $error("head_time expected %0h got %0h", e.head_time, rsp.head_time);
          fail_cnt++;
        end
        if (rsp.is_empty !== e.is_empty) begin
          $error("is_empty expected %0d got %0d", e.is_empty, rsp.is_empty);
          fail_cnt++;
        end
        if (rsp.occupancy !== e.occupancy) begin
          $error("occupancy expected %0d got %0d", e.occupancy, rsp.occupancy);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (in_flight != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (rsp_due.size() != 0) begin
      $error("%0d result words never arrived", rsp_due.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
